// ----- hw/rtl/sm83_opcode_predecoder_unit_assert.svh -----
// assertion macros shared by the predecoder rtl
// no dependencies; pulled in with an include at the end of a module body
`ifndef SM83_OPCODE_PREDECODER_UNIT_ASSERT_SVH
`define SM83_OPCODE_PREDECODER_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SM83PD_ASSERT_IMPL(name, clock, reset, pre, post) \
  name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
    else $error("sm83pd: same-cycle check failed");

// next-cycle implication, checked outside reset
`define SM83PD_ASSERT_NEXT(name, clock, reset, pre, post) \
  name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
    else $error("sm83pd: next-cycle check failed");

`endif

// ----- hw/rtl/sm83pd_pkg.sv -----
// types, operand/mnemonic/condition codes and small helpers of the sm83 predecoder
// no dependencies
package sm83pd_pkg;

  typedef logic [1:0] len_t;
  typedef logic [5:0] mnem_t;
  typedef logic [4:0] opd_t;
  typedef logic [2:0] cond_t;

  // opcodes with a meaning of their own
  localparam logic [7:0] OPC_PREFIX = 8'hCB;
  localparam logic [7:0] OPC_HALT   = 8'h76;

  // mnemonic codes
  localparam mnem_t MN_BIT  = 6'd8;
  localparam mnem_t MN_HALT = 6'd11;
  localparam mnem_t MN_LD   = 6'd12;
  localparam mnem_t MN_ADD  = 6'd13;
  localparam mnem_t MN_NOP  = 6'd21;
  localparam mnem_t MN_STOP = 6'd22;
  localparam mnem_t MN_JR   = 6'd23;
  localparam mnem_t MN_INC  = 6'd24;
  localparam mnem_t MN_DEC  = 6'd25;
  localparam mnem_t MN_RLCA = 6'd26;
  localparam mnem_t MN_RET  = 6'd34;
  localparam mnem_t MN_LDH  = 6'd35;
  localparam mnem_t MN_POP  = 6'd36;
  localparam mnem_t MN_RETI = 6'd37;
  localparam mnem_t MN_JP   = 6'd38;
  localparam mnem_t MN_DI   = 6'd39;
  localparam mnem_t MN_EI   = 6'd40;
  localparam mnem_t MN_ILL  = 6'd41;
  localparam mnem_t MN_CALL = 6'd42;
  localparam mnem_t MN_PUSH = 6'd43;
  localparam mnem_t MN_RST  = 6'd44;

  // operand codes
  localparam opd_t OPD_NONE = 5'd0;
  localparam opd_t OPD_B    = 5'd1;
  localparam opd_t OPD_A    = 5'd8;
  localparam opd_t OPD_BC   = 5'd9;
  localparam opd_t OPD_HL   = 5'd11;
  localparam opd_t OPD_SP   = 5'd12;
  localparam opd_t OPD_AF   = 5'd13;
  localparam opd_t OPD_IBC  = 5'd14;
  localparam opd_t OPD_IA16 = 5'd18;
  localparam opd_t OPD_IA8  = 5'd19;
  localparam opd_t OPD_IC   = 5'd20;
  localparam opd_t OPD_D8   = 5'd21;
  localparam opd_t OPD_D16  = 5'd22;
  localparam opd_t OPD_E8   = 5'd23;
  localparam opd_t OPD_SPE  = 5'd24;
  localparam opd_t OPD_TGT  = 5'd25;

  // condition codes
  localparam cond_t COND_ALWAYS = 3'd0;
  localparam cond_t COND_NZ     = 3'd1;
  localparam cond_t COND_C      = 3'd4;

  localparam len_t LEN_1 = 2'd1;
  localparam len_t LEN_2 = 2'd2;
  localparam len_t LEN_3 = 2'd3;

  // how the last stage forms the branch target
  typedef enum logic [1:0] {
    TGT_NONE = 2'd0,
    TGT_REL  = 2'd1,
    TGT_ABS  = 2'd2,
    TGT_RST  = 2'd3
  } tgt_sel_t;

  // decoded item between the decode and target stages
  typedef struct packed {
    len_t        instr_length;
    mnem_t       mnemonic;
    opd_t        dest_operand;
    opd_t        src_operand;
    cond_t       condition;
    logic [2:0]  bit_index;
    logic [15:0] immediate;
    logic        illegal;
    tgt_sel_t    tgt_sel;
    logic [2:0]  rst_vec;
    logic [15:0] instr_address;
  } dec_t;

  function automatic opd_t reg8(input logic [2:0] i);
    return OPD_B + {2'b00, i};
  endfunction

  function automatic opd_t pair_sp(input logic [1:0] p);
    return OPD_BC + {3'b000, p};
  endfunction

  function automatic opd_t pair_af(input logic [1:0] p);
    return (p == 2'd3) ? OPD_AF : OPD_BC + {3'b000, p};
  endfunction

endpackage

// ----- hw/rtl/sm83pd_in_if.sv -----
// fetch-side channel of the predecoder: instruction address and three bytes
// depends on nothing
interface sm83pd_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] instr_address;
  logic [7:0]  opcode_byte;
  logic [7:0]  second_byte;
  logic [7:0]  third_byte;

  modport source (output valid, output instr_address, output opcode_byte,
                  output second_byte, output third_byte, input ready);
  modport sink   (input valid, input instr_address, input opcode_byte,
                  input second_byte, input third_byte, output ready);
endinterface

// ----- hw/rtl/sm83pd_out_if.sv -----
// result channel of the predecoder: one decoded instruction per beat
// depends on sm83pd_pkg
interface sm83pd_out_if;
  import sm83pd_pkg::*;

  logic        valid;
  logic        ready;
  len_t        instr_length;
  mnem_t       mnemonic;
  opd_t        dest_operand;
  opd_t        src_operand;
  cond_t       condition;
  logic [2:0]  bit_index;
  logic [15:0] immediate;
  logic [15:0] branch_target;
  logic        illegal;

  modport source (output valid, output instr_length, output mnemonic,
                  output dest_operand, output src_operand, output condition,
                  output bit_index, output immediate, output branch_target,
                  output illegal, input ready);
  modport sink   (input valid, input instr_length, input mnemonic,
                  input dest_operand, input src_operand, input condition,
                  input bit_index, input immediate, input branch_target,
                  input illegal, output ready);
endinterface

// ----- hw/rtl/sm83_opcode_predecoder_unit.sv -----
// sm83 opcode predecoder, three-stage valid/ready pipeline
// depends on sm83pd_pkg, sm83pd_in_if, sm83pd_out_if and the assert macro header
//
// instr carries one instruction per beat: its address and the opcode byte with
// the two bytes after it (unused bytes may hold anything). result carries one
// decoded beat per instruction, in order: length, mnemonic, operands, condition,
// bit index, immediate, branch target and the illegal flag.
// stage 1 registers the fetched bytes, stage 2 decodes the opcode fields
// (including the prefixed page) and stage 3 forms the branch target and holds
// the result. a beat accepted on instr is held in the stage 1 register, then in
// the stage 2 register and then in the result register, and throughput is one
// beat per cycle while result.ready is high.
// each stage loads when it is empty or when the stage after it moves, so a
// stall on result.ready backs up one stage at a time; instr.ready drops only
// when all three stages are full and result.ready is low, and no beat is
// dropped or repeated.
// rst is synchronous and empties all stages; the data registers are not reset.
module sm83_opcode_predecoder_unit (
  input logic clk,
  input logic rst,
  sm83pd_in_if.sink    instr,
  sm83pd_out_if.source result
);
  import sm83pd_pkg::*;

  logic        s1_valid;
  logic [15:0] s1_addr;
  logic [7:0]  s1_op;
  logic [7:0]  s1_b1;
  logic [7:0]  s1_b2;

  logic s2_valid;
  dec_t s2_dec;
  dec_t dec_next;

  logic        s3_valid;
  logic [15:0] tgt_next;

  logic s1_en;
  logic s2_en;
  logic s3_en;

  assign s3_en = !s3_valid || result.ready;
  assign s2_en = !s2_valid || s3_en;
  assign s1_en = !s1_valid || s2_en;
  assign instr.ready = s1_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (s1_en) s1_valid <= instr.valid;
      if (s2_en) s2_valid <= s1_valid;
      if (s3_en) s3_valid <= s2_valid;
    end
  end

  // stage 1: capture the fetched bytes
  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_addr <= instr.instr_address;
      s1_op   <= instr.opcode_byte;
      s1_b1   <= instr.second_byte;
      s1_b2   <= instr.third_byte;
    end
  end

  // stage 2: opcode decode
  always_comb begin
    logic [1:0]  x;
    logic [2:0]  y;
    logic [2:0]  z;
    logic [1:0]  p;
    logic        q;
    logic [1:0]  cx;
    logic [2:0]  cy;
    logic [2:0]  cz;
    logic [15:0] d16;
    logic [15:0] e16;
    logic [15:0] d8;
    logic        ill;

    x   = s1_op[7:6];
    y   = s1_op[5:3];
    z   = s1_op[2:0];
    p   = y[2:1];
    q   = y[0];
    cx  = s1_b1[7:6];
    cy  = s1_b1[5:3];
    cz  = s1_b1[2:0];
    d16 = {s1_b2, s1_b1};
    e16 = {{8{s1_b1[7]}}, s1_b1};
    d8  = {8'h00, s1_b1};
    ill = 1'b0;

    dec_next               = '0;
    dec_next.instr_length  = LEN_1;
    dec_next.mnemonic      = MN_NOP;
    dec_next.tgt_sel       = TGT_NONE;
    dec_next.rst_vec       = y;
    dec_next.instr_address = s1_addr;

    if (s1_op == OPC_PREFIX) begin
      dec_next.instr_length = LEN_2;
      dec_next.dest_operand = reg8(cz);
      if (cx == 2'd0) begin
        dec_next.mnemonic = {3'b000, cy};
      end else begin
        dec_next.mnemonic  = MN_BIT + {4'b0000, cx} - 6'd1;
        dec_next.bit_index = cy;
      end
    end else begin
      unique case (x)
        2'd1: begin
          if (s1_op == OPC_HALT) begin
            dec_next.mnemonic = MN_HALT;
          end else begin
            dec_next.mnemonic     = MN_LD;
            dec_next.dest_operand = reg8(y);
            dec_next.src_operand  = reg8(z);
          end
        end
        2'd2: begin
          dec_next.mnemonic     = MN_ADD + {3'b000, y};
          dec_next.dest_operand = OPD_A;
          dec_next.src_operand  = reg8(z);
        end
        2'd0: begin
          unique case (z)
            3'd0: begin
              if (y == 3'd0) begin
                dec_next.mnemonic = MN_NOP;
              end else if (y == 3'd1) begin
                dec_next.instr_length = LEN_3;
                dec_next.mnemonic     = MN_LD;
                dec_next.dest_operand = OPD_IA16;
                dec_next.src_operand  = OPD_SP;
                dec_next.immediate    = d16;
              end else if (y == 3'd2) begin
                dec_next.instr_length = LEN_2;
                dec_next.mnemonic     = MN_STOP;
              end else begin
                dec_next.instr_length = LEN_2;
                dec_next.mnemonic     = MN_JR;
                dec_next.dest_operand = OPD_TGT;
                dec_next.condition    = (y == 3'd3) ? COND_ALWAYS : y - 3'd3;
                dec_next.immediate    = e16;
                dec_next.tgt_sel      = TGT_REL;
              end
            end
            3'd1: begin
              if (!q) begin
                dec_next.instr_length = LEN_3;
                dec_next.mnemonic     = MN_LD;
                dec_next.dest_operand = pair_sp(p);
                dec_next.src_operand  = OPD_D16;
                dec_next.immediate    = d16;
              end else begin
                dec_next.mnemonic     = MN_ADD;
                dec_next.dest_operand = OPD_HL;
                dec_next.src_operand  = pair_sp(p);
              end
            end
            3'd2: begin
              dec_next.mnemonic = MN_LD;
              if (!q) begin
                dec_next.dest_operand = OPD_IBC + {3'b000, p};
                dec_next.src_operand  = OPD_A;
              end else begin
                dec_next.dest_operand = OPD_A;
                dec_next.src_operand  = OPD_IBC + {3'b000, p};
              end
            end
            3'd3: begin
              dec_next.mnemonic     = q ? MN_DEC : MN_INC;
              dec_next.dest_operand = pair_sp(p);
            end
            3'd4: begin
              dec_next.mnemonic     = MN_INC;
              dec_next.dest_operand = reg8(y);
            end
            3'd5: begin
              dec_next.mnemonic     = MN_DEC;
              dec_next.dest_operand = reg8(y);
            end
            3'd6: begin
              dec_next.instr_length = LEN_2;
              dec_next.mnemonic     = MN_LD;
              dec_next.dest_operand = reg8(y);
              dec_next.src_operand  = OPD_D8;
              dec_next.immediate    = d8;
            end
            default: begin
              dec_next.mnemonic = MN_RLCA + {3'b000, y};
            end
          endcase
        end
        default: begin
          unique case (z)
            3'd0: begin
              if (!y[2]) begin
                dec_next.mnemonic  = MN_RET;
                dec_next.condition = {1'b0, y[1:0]} + COND_NZ;
              end else begin
                dec_next.instr_length = LEN_2;
                unique case (y[1:0])
                  2'd0: begin
                    dec_next.mnemonic     = MN_LDH;
                    dec_next.dest_operand = OPD_IA8;
                    dec_next.src_operand  = OPD_A;
                    dec_next.immediate    = d8;
                  end
                  2'd1: begin
                    dec_next.mnemonic     = MN_ADD;
                    dec_next.dest_operand = OPD_SP;
                    dec_next.src_operand  = OPD_E8;
                    dec_next.immediate    = e16;
                  end
                  2'd2: begin
                    dec_next.mnemonic     = MN_LDH;
                    dec_next.dest_operand = OPD_A;
                    dec_next.src_operand  = OPD_IA8;
                    dec_next.immediate    = d8;
                  end
                  default: begin
                    dec_next.mnemonic     = MN_LD;
                    dec_next.dest_operand = OPD_HL;
                    dec_next.src_operand  = OPD_SPE;
                    dec_next.immediate    = e16;
                  end
                endcase
              end
            end
            3'd1: begin
              if (!q) begin
                dec_next.mnemonic     = MN_POP;
                dec_next.dest_operand = pair_af(p);
              end else begin
                unique case (p)
                  2'd0: dec_next.mnemonic = MN_RET;
                  2'd1: dec_next.mnemonic = MN_RETI;
                  2'd2: begin
                    // jump through hl: target unknown at decode
                    dec_next.mnemonic     = MN_JP;
                    dec_next.dest_operand = OPD_HL;
                  end
                  default: begin
                    dec_next.mnemonic     = MN_LD;
                    dec_next.dest_operand = OPD_SP;
                    dec_next.src_operand  = OPD_HL;
                  end
                endcase
              end
            end
            3'd2: begin
              if (!y[2]) begin
                dec_next.instr_length = LEN_3;
                dec_next.mnemonic     = MN_JP;
                dec_next.dest_operand = OPD_TGT;
                dec_next.condition    = {1'b0, y[1:0]} + COND_NZ;
                dec_next.immediate    = d16;
                dec_next.tgt_sel      = TGT_ABS;
              end else begin
                unique case (y[1:0])
                  2'd0: begin
                    dec_next.mnemonic     = MN_LDH;
                    dec_next.dest_operand = OPD_IC;
                    dec_next.src_operand  = OPD_A;
                  end
                  2'd1: begin
                    dec_next.instr_length = LEN_3;
                    dec_next.mnemonic     = MN_LD;
                    dec_next.dest_operand = OPD_IA16;
                    dec_next.src_operand  = OPD_A;
                    dec_next.immediate    = d16;
                  end
                  2'd2: begin
                    dec_next.mnemonic     = MN_LDH;
                    dec_next.dest_operand = OPD_A;
                    dec_next.src_operand  = OPD_IC;
                  end
                  default: begin
                    dec_next.instr_length = LEN_3;
                    dec_next.mnemonic     = MN_LD;
                    dec_next.dest_operand = OPD_A;
                    dec_next.src_operand  = OPD_IA16;
                    dec_next.immediate    = d16;
                  end
                endcase
              end
            end
            3'd3: begin
              if (y == 3'd0) begin
                dec_next.instr_length = LEN_3;
                dec_next.mnemonic     = MN_JP;
                dec_next.dest_operand = OPD_TGT;
                dec_next.immediate    = d16;
                dec_next.tgt_sel      = TGT_ABS;
              end else if (y == 3'd6) begin
                dec_next.mnemonic = MN_DI;
              end else if (y == 3'd7) begin
                dec_next.mnemonic = MN_EI;
              end else begin
                ill = 1'b1;
              end
            end
            3'd4: begin
              if (!y[2]) begin
                dec_next.instr_length = LEN_3;
                dec_next.mnemonic     = MN_CALL;
                dec_next.dest_operand = OPD_TGT;
                dec_next.condition    = {1'b0, y[1:0]} + COND_NZ;
                dec_next.immediate    = d16;
                dec_next.tgt_sel      = TGT_ABS;
              end else begin
                ill = 1'b1;
              end
            end
            3'd5: begin
              if (!q) begin
                dec_next.mnemonic     = MN_PUSH;
                dec_next.dest_operand = pair_af(p);
              end else if (p == 2'd0) begin
                dec_next.instr_length = LEN_3;
                dec_next.mnemonic     = MN_CALL;
                dec_next.dest_operand = OPD_TGT;
                dec_next.immediate    = d16;
                dec_next.tgt_sel      = TGT_ABS;
              end else begin
                ill = 1'b1;
              end
            end
            3'd6: begin
              dec_next.instr_length = LEN_2;
              dec_next.mnemonic     = MN_ADD + {3'b000, y};
              dec_next.dest_operand = OPD_A;
              dec_next.src_operand  = OPD_D8;
              dec_next.immediate    = d8;
            end
            default: begin
              dec_next.mnemonic     = MN_RST;
              dec_next.dest_operand = OPD_TGT;
              dec_next.tgt_sel      = TGT_RST;
            end
          endcase
        end
      endcase
    end

    // unused opcodes: everything but length, mnemonic and the flag is zero
    if (ill) begin
      dec_next              = '0;
      dec_next.instr_length = LEN_1;
      dec_next.mnemonic     = MN_ILL;
      dec_next.illegal      = 1'b1;
      dec_next.tgt_sel      = TGT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en) s2_dec <= dec_next;
  end

  // stage 3: branch target
  always_comb begin
    unique case (s2_dec.tgt_sel)
      TGT_REL:  tgt_next = s2_dec.instr_address + 16'd2 + s2_dec.immediate;
      TGT_ABS:  tgt_next = s2_dec.immediate;
      TGT_RST:  tgt_next = {10'd0, s2_dec.rst_vec, 3'b000};
      default:  tgt_next = 16'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (s3_en) begin
      result.instr_length  <= s2_dec.instr_length;
      result.mnemonic      <= s2_dec.mnemonic;
      result.dest_operand  <= s2_dec.dest_operand;
      result.src_operand   <= s2_dec.src_operand;
      result.condition     <= s2_dec.condition;
      result.bit_index     <= s2_dec.bit_index;
      result.immediate     <= s2_dec.immediate;
      result.branch_target <= tgt_next;
      result.illegal       <= s2_dec.illegal;
    end
  end

  assign result.valid = s3_valid;

  `include "sm83_opcode_predecoder_unit_assert.svh"

  `SM83PD_ASSERT_NEXT(a_s1_fill, clk, rst, instr.valid && instr.ready, s1_valid)
  `SM83PD_ASSERT_NEXT(a_s2_fill, clk, rst, s1_valid && s2_en, s2_valid)
  `SM83PD_ASSERT_NEXT(a_s3_fill, clk, rst, s2_valid && s3_en, result.valid)
  `SM83PD_ASSERT_IMPL(a_ill_form, clk, rst, result.valid && result.illegal, result.instr_length == LEN_1 && result.mnemonic == MN_ILL && result.branch_target == 16'd0)
  `SM83PD_ASSERT_IMPL(a_rst_form, clk, rst, result.valid && result.mnemonic == MN_RST, result.branch_target[2:0] == 3'b000 && result.immediate == 16'd0)
  `SM83PD_ASSERT_IMPL(a_cond_range, clk, rst, result.valid, result.condition <= COND_C)

endmodule

// ----- dv/tb_sm83_opcode_predecoder_unit.sv -----
// self-checking testbench for the sm83 opcode predecoder pipeline
// depends on sm83pd_pkg, sm83pd_in_if, sm83pd_out_if and sm83_opcode_predecoder_unit
// instruction beats are decoded by a local predictor and compared with every result beat
module tb_sm83_opcode_predecoder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import sm83pd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES = 8;
  localparam int MAX_REPORTS = 40;
  localparam int STALL_PERCENT = 7;
  localparam mnem_t MN_RLC = 6'd0;

  typedef struct packed {
    len_t        len;
    mnem_t       mn;
    opd_t        dst;
    opd_t        src;
    cond_t       cond;
    logic [2:0]  bit_idx;
    logic [15:0] imm;
    logic [15:0] tgt;
    logic        ill;
  } decode_t;

  logic clk = 1'b0;
  logic rst;

  sm83pd_in_if  instr_ch ();
  sm83pd_out_if result_ch ();

  sm83_opcode_predecoder_unit uut (
    .clk    (clk),
    .rst    (rst),
    .instr  (instr_ch),
    .result (result_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  decode_t     pending_decodes [$];
  bit          steady;
  int          errors;
  int          n_decoded;
  int          n_prefixed;
  int          n_illegal;
  int          n_transfers;
  int          idle_cycles;
  logic [7:0]  byte_order [256];

  // ---------------------------------------------------------------------------
  // predictor

  function automatic decode_t make_decode(input len_t len, input mnem_t mn,
                                          input opd_t dst, input opd_t src);
    decode_t r;
    r = '0;
    r.len = len;
    r.mn = mn;
    r.dst = dst;
    r.src = src;
    return r;
  endfunction

  function automatic opd_t reg_code(input logic [2:0] i);
    return OPD_B + opd_t'(i);
  endfunction

  function automatic opd_t pair_code(input logic [1:0] p, input bit with_af);
    if (with_af && p == 2'd3) begin
      return OPD_AF;
    end
    return OPD_BC + opd_t'(p);
  endfunction

  function automatic decode_t predict_decode(input logic [15:0] addr, input logic [7:0] op,
                                             input logic [7:0] b1, input logic [7:0] b2);
    logic [1:0]  x;
    logic [2:0]  y;
    logic [2:0]  z;
    logic [1:0]  p;
    logic        q;
    logic [1:0]  cx;
    logic [2:0]  cy;
    logic [2:0]  cz;
    logic [15:0] d16;
    logic [15:0] e16;
    decode_t     r;
    decode_t     bad;
    x = op[7:6];
    y = op[5:3];
    z = op[2:0];
    p = y[2:1];
    q = y[0];
    cx = b1[7:6];
    cy = b1[5:3];
    cz = b1[2:0];
    d16 = {b2, b1};
    e16 = {{8{b1[7]}}, b1};
    bad = '0;
    bad.len = LEN_1;
    bad.mn = MN_ILL;
    bad.ill = 1'b1;
    r = make_decode(LEN_1, MN_NOP, OPD_NONE, OPD_NONE);

    if (op == OPC_PREFIX) begin
      if (cx == 2'd0) begin
        r = make_decode(LEN_2, MN_RLC + mnem_t'(cy), reg_code(cz), OPD_NONE);
      end else begin
        // bit, res, set follow each other
        r = make_decode(LEN_2, MN_BIT + mnem_t'(cx) - 6'd1, reg_code(cz), OPD_NONE);
        r.bit_idx = cy;
      end
    end else if (x == 2'd1) begin
      if (op == OPC_HALT) begin
        r = make_decode(LEN_1, MN_HALT, OPD_NONE, OPD_NONE);
      end else begin
        r = make_decode(LEN_1, MN_LD, reg_code(y), reg_code(z));
      end
    end else if (x == 2'd2) begin
      r = make_decode(LEN_1, MN_ADD + mnem_t'(y), OPD_A, reg_code(z));
    end else if (x == 2'd0) begin
      case (z)
        3'd0: begin
          if (y == 3'd0) begin
            r = make_decode(LEN_1, MN_NOP, OPD_NONE, OPD_NONE);
          end else if (y == 3'd1) begin
            r = make_decode(LEN_3, MN_LD, OPD_IA16, OPD_SP);
            r.imm = d16;
          end else if (y == 3'd2) begin
            r = make_decode(LEN_2, MN_STOP, OPD_NONE, OPD_NONE);
          end else begin
            r = make_decode(LEN_2, MN_JR, OPD_TGT, OPD_NONE);
            r.cond = (y == 3'd3) ? COND_ALWAYS : COND_NZ + cond_t'(y - 3'd4);
            r.imm = e16;
            r.tgt = addr + 16'd2 + e16;
          end
        end
        3'd1: begin
          if (!q) begin
            r = make_decode(LEN_3, MN_LD, pair_code(p, 1'b0), OPD_D16);
            r.imm = d16;
          end else begin
            r = make_decode(LEN_1, MN_ADD, OPD_HL, pair_code(p, 1'b0));
          end
        end
        3'd2: begin
          if (!q) begin
            r = make_decode(LEN_1, MN_LD, OPD_IBC + opd_t'(p), OPD_A);
          end else begin
            r = make_decode(LEN_1, MN_LD, OPD_A, OPD_IBC + opd_t'(p));
          end
        end
        3'd3: r = make_decode(LEN_1, q ? MN_DEC : MN_INC, pair_code(p, 1'b0), OPD_NONE);
        3'd4: r = make_decode(LEN_1, MN_INC, reg_code(y), OPD_NONE);
        3'd5: r = make_decode(LEN_1, MN_DEC, reg_code(y), OPD_NONE);
        3'd6: begin
          r = make_decode(LEN_2, MN_LD, reg_code(y), OPD_D8);
          r.imm = {8'h00, b1};
        end
        default: r = make_decode(LEN_1, MN_RLCA + mnem_t'(y), OPD_NONE, OPD_NONE);
      endcase
    end else begin
      case (z)
        3'd0: begin
          if (!y[2]) begin
            r = make_decode(LEN_1, MN_RET, OPD_NONE, OPD_NONE);
            r.cond = COND_NZ + cond_t'(y);
          end else if (y == 3'd4) begin
            r = make_decode(LEN_2, MN_LDH, OPD_IA8, OPD_A);
            r.imm = {8'h00, b1};
          end else if (y == 3'd5) begin
            r = make_decode(LEN_2, MN_ADD, OPD_SP, OPD_E8);
            r.imm = e16;
          end else if (y == 3'd6) begin
            r = make_decode(LEN_2, MN_LDH, OPD_A, OPD_IA8);
            r.imm = {8'h00, b1};
          end else begin
            r = make_decode(LEN_2, MN_LD, OPD_HL, OPD_SPE);
            r.imm = e16;
          end
        end
        3'd1: begin
          if (!q) begin
            r = make_decode(LEN_1, MN_POP, pair_code(p, 1'b1), OPD_NONE);
          end else if (p == 2'd0) begin
            r = make_decode(LEN_1, MN_RET, OPD_NONE, OPD_NONE);
          end else if (p == 2'd1) begin
            r = make_decode(LEN_1, MN_RETI, OPD_NONE, OPD_NONE);
          end else if (p == 2'd2) begin
            // jump through hl: target unknown at decode
            r = make_decode(LEN_1, MN_JP, OPD_HL, OPD_NONE);
          end else begin
            r = make_decode(LEN_1, MN_LD, OPD_SP, OPD_HL);
          end
        end
        3'd2: begin
          if (!y[2]) begin
            r = make_decode(LEN_3, MN_JP, OPD_TGT, OPD_NONE);
            r.cond = COND_NZ + cond_t'(y);
            r.imm = d16;
            r.tgt = d16;
          end else if (y == 3'd4) begin
            r = make_decode(LEN_1, MN_LDH, OPD_IC, OPD_A);
          end else if (y == 3'd5) begin
            r = make_decode(LEN_3, MN_LD, OPD_IA16, OPD_A);
            r.imm = d16;
          end else if (y == 3'd6) begin
            r = make_decode(LEN_1, MN_LDH, OPD_A, OPD_IC);
          end else begin
            r = make_decode(LEN_3, MN_LD, OPD_A, OPD_IA16);
            r.imm = d16;
          end
        end
        3'd3: begin
          if (y == 3'd0) begin
            r = make_decode(LEN_3, MN_JP, OPD_TGT, OPD_NONE);
            r.imm = d16;
            r.tgt = d16;
          end else if (y == 3'd6) begin
            r = make_decode(LEN_1, MN_DI, OPD_NONE, OPD_NONE);
          end else if (y == 3'd7) begin
            r = make_decode(LEN_1, MN_EI, OPD_NONE, OPD_NONE);
          end else begin
            r = bad;
          end
        end
        3'd4: begin
          if (!y[2]) begin
            r = make_decode(LEN_3, MN_CALL, OPD_TGT, OPD_NONE);
            r.cond = COND_NZ + cond_t'(y);
            r.imm = d16;
            r.tgt = d16;
          end else begin
            r = bad;
          end
        end
        3'd5: begin
          if (!q) begin
            r = make_decode(LEN_1, MN_PUSH, pair_code(p, 1'b1), OPD_NONE);
          end else if (p == 2'd0) begin
            r = make_decode(LEN_3, MN_CALL, OPD_TGT, OPD_NONE);
            r.imm = d16;
            r.tgt = d16;
          end else begin
            r = bad;
          end
        end
        3'd6: begin
          r = make_decode(LEN_2, MN_ADD + mnem_t'(y), OPD_A, OPD_D8);
          r.imm = {8'h00, b1};
        end
        default: begin
          r = make_decode(LEN_1, MN_RST, OPD_TGT, OPD_NONE);
          r.tgt = {10'd0, y, 3'd0};
        end
      endcase
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // checking

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      errors++;
      if (errors <= MAX_REPORTS) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
    end
  endtask

  always @(posedge clk) begin
    decode_t want;
    if (!rst) begin
      // pop before push so a result with nothing pending is caught
      if (result_ch.valid && result_ch.ready) begin
        if (pending_decodes.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("%0t: result beat with nothing pending, expected none, got mnemonic %0h",
                     $time, result_ch.mnemonic);
          end
        end else begin
          want = pending_decodes.pop_front();
          check_field("instr_length", want.len, result_ch.instr_length);
          check_field("mnemonic", want.mn, result_ch.mnemonic);
          check_field("dest_operand", want.dst, result_ch.dest_operand);
          check_field("src_operand", want.src, result_ch.src_operand);
          check_field("condition", want.cond, result_ch.condition);
          check_field("bit_index", want.bit_idx, result_ch.bit_index);
          check_field("immediate", want.imm, result_ch.immediate);
          check_field("branch_target", want.tgt, result_ch.branch_target);
          check_field("illegal", want.ill, result_ch.illegal);
        end
      end
      if (instr_ch.valid && instr_ch.ready) begin
        want = predict_decode(instr_ch.instr_address, instr_ch.opcode_byte,
                              instr_ch.second_byte, instr_ch.third_byte);
        pending_decodes.push_back(want);
        n_decoded++;
        if (instr_ch.opcode_byte == OPC_PREFIX) n_prefixed++;
        if (want.ill) n_illegal++;
        if (want.mn == MN_JR || want.mn == MN_JP || want.mn == MN_CALL ||
            want.mn == MN_RST || want.mn == MN_RET || want.mn == MN_RETI) begin
          n_transfers++;
        end
      end
    end
  end

  // cycles with no beat on either channel
  always @(posedge clk) begin
    if (!rst) begin
      if ((instr_ch.valid && instr_ch.ready) || (result_ch.valid && result_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired with %0d results outstanding", $time,
                 pending_decodes.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  // result side stalls
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      result_ch.ready <= steady || ($urandom_range(99) >= STALL_PERCENT);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(15))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [15:0] rand_addr();
    case ($urandom_range(15))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'hFFFE;
      3: return 16'h7FFF;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  task automatic shuffle_byte_order();
    int j;
    logic [7:0] t;
    for (int i = 0; i < 256; i++) byte_order[i] = 8'(i);
    for (int i = 255; i > 0; i--) begin
      j = $urandom_range(i);
      t = byte_order[i];
      byte_order[i] = byte_order[j];
      byte_order[j] = t;
    end
  endtask

  // one instruction beat; returns at the edge that accepts it
  task automatic send_instr(input logic [15:0] addr, input logic [7:0] op,
                            input logic [7:0] b1, input logic [7:0] b2);
    while (!steady && $urandom_range(99) < STALL_PERCENT) begin
      @(negedge clk);
      instr_ch.valid <= 1'b0;
    end
    @(negedge clk);
    instr_ch.valid <= 1'b1;
    instr_ch.instr_address <= addr;
    instr_ch.opcode_byte <= op;
    instr_ch.second_byte <= b1;
    instr_ch.third_byte <= b2;
    do begin
      @(posedge clk);
    end while (!(instr_ch.valid && instr_ch.ready));
  endtask

  // hold off the sender until every pending result is back
  task automatic drain_results();
    @(negedge clk);
    instr_ch.valid <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // tests

  task automatic test_directed_cases();
    send_instr(16'h0000, 8'h00, 8'h00, 8'h00);   // nop
    send_instr(16'hFFFF, 8'hFF, 8'hFF, 8'hFF);   // rst 38h
    send_instr(16'h1234, OPC_PREFIX, 8'h00, 8'hFF); // rlc b
    send_instr(16'h1235, OPC_PREFIX, 8'hFF, 8'h00); // set 7,a
    send_instr(16'h2000, OPC_PREFIX, 8'h46, 8'hAA); // bit 0,(hl)
    send_instr(16'h2000, OPC_PREFIX, 8'h86, 8'h55); // res 0,(hl)
    send_instr(16'h2002, OPC_PREFIX, 8'h37, 8'h00); // swap a
    send_instr(16'h0100, OPC_HALT, 8'hFF, 8'hFF);
    send_instr(16'h0101, 8'h40, 8'h00, 8'h00);   // ld b,b
    send_instr(16'h0102, 8'hBF, 8'h00, 8'h00);   // cp a
    send_instr(16'hFFFE, 8'h18, 8'h7F, 8'h00);   // jr forward, wraps past ffff
    send_instr(16'h0000, 8'h38, 8'h80, 8'hFF);   // jr c backward, wraps below zero
    send_instr(16'h0200, 8'h10, 8'hFF, 8'hFF);   // stop ignores its second byte
    send_instr(16'h0300, 8'h08, 8'hFF, 8'hFF);   // ld (a16),sp
    send_instr(16'h0400, 8'hE9, 8'h12, 8'h34);   // jp hl
    send_instr(16'h0500, 8'hC2, 8'h34, 8'h12);   // jp nz
    send_instr(16'h0600, 8'hDC, 8'h00, 8'h80);   // call c
    send_instr(16'h0700, 8'hCD, 8'hFF, 8'hFF);   // call
    send_instr(16'h0800, 8'hC3, 8'h00, 8'h00);   // jp
    send_instr(16'h0900, 8'hE8, 8'h80, 8'h00);   // add sp,e8
    send_instr(16'h0A00, 8'hF8, 8'hFF, 8'h00);   // ld hl,sp+e8
    send_instr(16'h0B00, 8'hF5, 8'h00, 8'h00);   // push af
    send_instr(16'h0C00, 8'hE2, 8'h00, 8'h00);   // ldh (c),a
    send_instr(16'h0D00, 8'hD3, 8'hFF, 8'hFF);   // unused opcodes
    send_instr(16'h0D01, 8'hDD, 8'h00, 8'h00);
    send_instr(16'h0D02, 8'hFD, 8'h80, 8'h80);
    drain_results();
  endtask

  task automatic test_base_opcode_sweep();
    shuffle_byte_order();
    for (int i = 0; i < 256; i++) begin
      send_instr(rand_addr(), byte_order[i], rand_byte(), rand_byte());
    end
    drain_results();
  endtask

  task automatic test_prefixed_sweep();
    shuffle_byte_order();
    for (int i = 0; i < 256; i++) begin
      send_instr(rand_addr(), OPC_PREFIX, byte_order[i], rand_byte());
    end
    drain_results();
  endtask

  task automatic test_random_stream();
    logic [7:0] op;
    for (int i = 0; i < 640; i++) begin
      // back-to-back stretch with no gaps on either side
      steady = (i >= 100 && i < 300);
      op = ($urandom_range(4) == 0) ? OPC_PREFIX : rand_byte();
      send_instr(rand_addr(), op, rand_byte(), rand_byte());
    end
    steady = 1'b0;
    drain_results();
  endtask

  initial begin
    rst = 1'b1;
    steady = 1'b0;
    errors = 0;
    n_decoded = 0;
    n_prefixed = 0;
    n_illegal = 0;
    n_transfers = 0;
    idle_cycles = 0;
    instr_ch.valid = 1'b0;
    instr_ch.instr_address = '0;
    instr_ch.opcode_byte = '0;
    instr_ch.second_byte = '0;
    instr_ch.third_byte = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_base_opcode_sweep();
    test_prefixed_sweep();
    test_random_stream();

    // allow for a stray beat after the last expected one
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("decoded %0d instructions: %0d prefixed, %0d unused opcodes, %0d control transfers",
             n_decoded, n_prefixed, n_illegal, n_transfers);
    $display("all base and prefixed opcodes swept with random operands, gaps and stalls on both sides");
    if (errors == 0 && pending_decodes.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
